// ----- rtl/pbh_pkg.sv -----
// Shared types, constants and the control store for the permutation byte hash.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package pbh_pkg;

	// item actions
	localparam logic [1:0] ACT_INIT   = 2'd0;
	localparam logic [1:0] ACT_ABSORB = 2'd1;
	localparam logic [1:0] ACT_FINAL  = 2'd2;

	// k left by the init recurrence k = ((k + 1) * z) mod 256, z = 0..255
	function automatic logic [7:0] init_k();
		logic [7:0] k;
		k = 8'd0;
		for (int z = 0; z < 256; z++) begin
			k = 8'(((32'(k) + 32'd1) * 32'(z)) & 32'hFF);
		end
		return k;
	endfunction

	localparam logic [7:0] INIT_K = init_k();

	// permutation read address select
	typedef enum logic [2:0] {
		PRD_NONE,
		PRD_I_NEXT,
		PRD_J_NEXT,
		PRD_C,
		PRD_K
	} prd_sel_t;

	// permutation write select
	typedef enum logic [1:0] {
		PWR_NONE,
		PWR_I_SJ,
		PWR_J_SI
	} pwr_sel_t;

	// sequencer jump kinds
	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_DISPATCH,
		JMP_IDLE,
		JMP_ROUND_END,
		JMP_FOLD_END
	} jmp_t;

	typedef logic [3:0] upc_t;

	// one control word
	typedef struct packed {
		prd_sel_t prd;
		pwr_sel_t pwr;
		logic     take_item;
		logic     init;
		logic     load_c;
		logic     upd_j;
		logic     load_sj;
		logic     upd_k;
		logic     dig_rd;
		logic     fold;
		logic     wait_out;
		jmp_t     jmp;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		uword_t uw;
		logic   exec;
		logic   take;
	} cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic fin;
		logic rnd_last;
		logic byte_last;
		logic out_free;
	} stat_t;

	// program addresses
	localparam upc_t UA_IDLE = 4'd0;
	localparam upc_t UA_INIT = 4'd1;
	localparam upc_t UA_FK   = 4'd2;
	localparam upc_t UA_R0   = 4'd3;
	localparam upc_t UA_R1   = 4'd4;
	localparam upc_t UA_R2   = 4'd5;
	localparam upc_t UA_R3   = 4'd6;
	localparam upc_t UA_D0   = 4'd7;
	localparam upc_t UA_D1   = 4'd8;

	localparam uword_t UW_NOP = '{
		prd: PRD_NONE, pwr: PWR_NONE, take_item: 1'b0, init: 1'b0, load_c: 1'b0,
		upd_j: 1'b0, load_sj: 1'b0, upd_k: 1'b0, dig_rd: 1'b0, fold: 1'b0,
		wait_out: 1'b0, jmp: JMP_IDLE
	};

	// control store
	function automatic uword_t ucode_rom(input upc_t a);
		uword_t uw;
		uw = UW_NOP;
		unique case (a)
			UA_IDLE: begin
				uw.take_item = 1'b1;
				uw.jmp       = JMP_DISPATCH;
			end
			UA_INIT: begin
				uw.init = 1'b1;
				uw.jmp  = JMP_IDLE;
			end
			// fetch perm[k] as the round byte
			UA_FK: begin
				uw.prd = PRD_K;
				uw.jmp = JMP_NEXT;
			end
			UA_R0: begin
				uw.prd    = PRD_I_NEXT;
				uw.load_c = 1'b1;
				uw.jmp    = JMP_NEXT;
			end
			UA_R1: begin
				uw.prd   = PRD_J_NEXT;
				uw.upd_j = 1'b1;
				uw.jmp   = JMP_NEXT;
			end
			UA_R2: begin
				uw.prd     = PRD_C;
				uw.pwr     = PWR_I_SJ;
				uw.load_sj = 1'b1;
				uw.jmp     = JMP_NEXT;
			end
			UA_R3: begin
				uw.pwr   = PWR_J_SI;
				uw.upd_k = 1'b1;
				uw.jmp   = JMP_ROUND_END;
			end
			UA_D0: begin
				uw.prd    = PRD_K;
				uw.dig_rd = 1'b1;
				uw.jmp    = JMP_NEXT;
			end
			UA_D1: begin
				uw.fold     = 1'b1;
				uw.wait_out = 1'b1;
				uw.jmp      = JMP_FOLD_END;
			end
			default: begin
				uw.jmp = JMP_IDLE;
			end
		endcase
		return uw;
	endfunction

endpackage

// ----- rtl/pbh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on a shared address; no dependencies.
module pbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pbh_useq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on pbh_pkg.
module pbh_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [1:0]       action,
	input  pbh_pkg::stat_t   stat,
	output logic             item_ready,
	output pbh_pkg::cmd_t    cmd
);

	import pbh_pkg::*;

	upc_t   upc_q;
	upc_t   upc_d;
	uword_t uw;

	// decode the current step
	always_comb begin
		uw         = ucode_rom(upc_q);
		cmd.uw     = uw;
		cmd.exec   = !(uw.wait_out && !stat.out_free);
		cmd.take   = uw.take_item && item_valid;
		item_ready = uw.take_item;
	end

	// select the next step; hold while stalled on the output slot
	always_comb begin
		upc_d = UA_IDLE;
		unique case (uw.jmp)
			JMP_NEXT: upc_d = upc_q + 4'd1;
			JMP_DISPATCH: begin
				if (item_valid) begin
					unique case (action)
						ACT_INIT:   upc_d = UA_INIT;
						ACT_ABSORB: upc_d = UA_R0;
						ACT_FINAL:  upc_d = UA_FK;
						default:    upc_d = UA_IDLE;
					endcase
				end
			end
			JMP_IDLE: upc_d = UA_IDLE;
			JMP_ROUND_END: begin
				if (!stat.fin) begin
					upc_d = UA_IDLE;
				end else if (stat.rnd_last) begin
					upc_d = UA_D0;
				end else begin
					upc_d = UA_FK;
				end
			end
			JMP_FOLD_END: upc_d = stat.byte_last ? UA_IDLE : UA_D0;
			default: upc_d = UA_IDLE;
		endcase
		if (!cmd.exec) begin
			upc_d = upc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	ap_final_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && action == ACT_FINAL |=> upc_q == UA_FK)
		else $error("finalize transaction did not start at the perm[k] fetch");

	ap_stall_only_fold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |-> upc_q == UA_D1)
		else $error("sequencer stalled outside the fold step");

	ap_absorb_return: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == UA_R3 && !stat.fin |=> upc_q == UA_IDLE)
		else $error("absorb round did not return to idle");

endmodule

// ----- rtl/pbh_dp.sv -----
// Datapath: permutation and digest RAMs with valid bits, i/j/k indices,
// round and byte counters, and the result register. Depends on pbh_pkg, pbh_ram.
module pbh_dp #(
	parameter int DIGEST_BYTES = 32,
	parameter int FINAL_ROUNDS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pbh_pkg::cmd_t  cmd,
	input  logic [1:0]     action,
	input  logic [7:0]     data_byte,
	input  logic           result_ready,
	output pbh_pkg::stat_t stat,
	output logic           result_valid,
	output logic [7:0]     digest_byte,
	output logic [4:0]     byte_index,
	output logic           last
);

	import pbh_pkg::*;

	localparam int DA_W = DIGEST_BYTES > 1 ? $clog2(DIGEST_BYTES) : 1;
	localparam int RC_W = FINAL_ROUNDS > 1 ? $clog2(FINAL_ROUNDS) : 1;

	logic                    go;
	logic [7:0]              i_q, j_q, k_q, c_q, si_q, sj_q;
	logic                    fin_q;
	logic [RC_W-1:0]         rcnt_q;
	logic [DA_W-1:0]         ncnt_q;
	logic [255:0]            pvld_q;
	logic [DIGEST_BYTES-1:0] dvld_q;
	logic                    pvld_rd_q, dvld_rd_q;
	logic [7:0]              praddr_q;
	logic [DA_W-1:0]         draddr_q;
	logic                    rv_q, last_q;
	logic [7:0]              dig_q;
	logic [4:0]              idx_q;

	logic       pre, pwe, dre, dwe;
	logic [7:0] praddr, pwaddr, pwdata, prdata, drdata;
	logic [7:0] peff, deff, jn, cval, fold_v;

	assign go = cmd.exec;

	// effective read data: an unwritten entry reads as its reset value
	assign peff   = pvld_rd_q ? prdata : praddr_q;
	assign deff   = dvld_rd_q ? drdata : 8'(draddr_q);
	assign jn     = {j_q[6:0], 1'b0} ^ (peff + c_q);
	assign fold_v = deff ^ peff;

	// perm[c] read during the swap: forward the swapped values
	always_comb begin
		priority if (c_q == j_q) begin
			cval = si_q;
		end else if (c_q == i_q) begin
			cval = sj_q;
		end else begin
			cval = peff;
		end
	end

	// permutation port control
	always_comb begin
		pre = go && (cmd.uw.prd != PRD_NONE);
		unique case (cmd.uw.prd)
			PRD_I_NEXT: praddr = i_q + 8'd1;
			PRD_J_NEXT: praddr = jn;
			PRD_C:      praddr = c_q;
			PRD_K:      praddr = k_q;
			default:    praddr = k_q;
		endcase
		pwe    = go && (cmd.uw.pwr != PWR_NONE);
		pwaddr = (cmd.uw.pwr == PWR_I_SJ) ? i_q : j_q;
		pwdata = (cmd.uw.pwr == PWR_I_SJ) ? peff : si_q;
		dre    = go && cmd.uw.dig_rd;
		dwe    = go && cmd.uw.fold;
	end

	pbh_ram #(.WIDTH(8), .DEPTH(256)) u_perm (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwaddr),
		.wdata (pwdata),
		.re    (pre),
		.raddr (praddr),
		.rdata (prdata)
	);

	pbh_ram #(.WIDTH(8), .DEPTH(DIGEST_BYTES)) u_digest (
		.clk   (clk),
		.we    (dwe),
		.waddr (ncnt_q),
		.wdata (fold_v),
		.re    (dre),
		.raddr (ncnt_q),
		.rdata (drdata)
	);

	// capture read side info alongside the RAM read
	always_ff @(posedge clk) begin
		if (pre) begin
			pvld_rd_q <= pvld_q[praddr];
			praddr_q  <= praddr;
		end
		if (dre) begin
			dvld_rd_q <= dvld_q[ncnt_q];
			draddr_q  <= ncnt_q;
		end
		if (cmd.take) begin
			c_q <= data_byte;
		end else if (go && cmd.uw.load_c && fin_q) begin
			c_q <= peff;
		end
		if (go && cmd.uw.upd_j) begin
			si_q <= peff;
		end
		if (go && cmd.uw.load_sj) begin
			sj_q <= peff;
		end
		if (dwe) begin
			dig_q  <= fold_v;
			idx_q  <= 5'(ncnt_q);
			last_q <= stat.byte_last;
		end
	end

	// indices, counters and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= 8'd0;
			j_q    <= 8'd0;
			k_q    <= INIT_K;
			fin_q  <= 1'b0;
			rcnt_q <= '0;
			ncnt_q <= '0;
			pvld_q <= '0;
			dvld_q <= '0;
		end else begin
			if (cmd.take) begin
				fin_q  <= (action == ACT_FINAL);
				rcnt_q <= '0;
				ncnt_q <= '0;
			end
			if (go && cmd.uw.init) begin
				i_q    <= 8'd0;
				j_q    <= 8'd0;
				k_q    <= INIT_K;
				pvld_q <= '0;
				dvld_q <= '0;
			end
			if (go && cmd.uw.prd == PRD_I_NEXT) begin
				i_q <= i_q + 8'd1;
			end
			if (go && cmd.uw.upd_j) begin
				j_q <= jn;
			end
			if (pwe) begin
				pvld_q[pwaddr] <= 1'b1;
			end
			if (go && cmd.uw.upd_k) begin
				k_q    <= {k_q[6:0], 1'b0} ^ (j_q + cval);
				rcnt_q <= rcnt_q + 1'b1;
			end
			if (dwe) begin
				k_q            <= k_q + fold_v;
				ncnt_q         <= ncnt_q + 1'b1;
				dvld_q[ncnt_q] <= 1'b1;
			end
		end
	end

	// result register: load on fold, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (dwe) begin
			rv_q <= 1'b1;
		end else if (result_ready) begin
			rv_q <= 1'b0;
		end
	end

	always_comb begin
		stat.fin       = fin_q;
		stat.rnd_last  = (rcnt_q == RC_W'(FINAL_ROUNDS - 1));
		stat.byte_last = (ncnt_q == DA_W'(DIGEST_BYTES - 1));
		stat.out_free  = !rv_q || result_ready;
	end

	assign result_valid = rv_q;
	assign digest_byte  = dig_q;
	assign byte_index   = idx_q;
	assign last         = last_q;

	ap_fold_slot: assert property (@(posedge clk) disable iff (!arst_n)
		dwe |-> (!rv_q || result_ready))
		else $error("digest byte folded while the result register was occupied");

	ap_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dwe && stat.byte_last |=> rv_q && last_q)
		else $error("final digest byte not flagged as last");

endmodule

// ----- rtl/permutation_byte_hash.sv -----
// Permutation byte hash, top level: microcode sequencer plus datapath.
// Depends on pbh_pkg, pbh_useq, pbh_dp (and pbh_ram through pbh_dp).
//
// Takes one item at a time (action, data_byte) and returns digest bytes in
// index order, last set on the final one. The block is driven by a small
// control store; every round makes four accesses to the 256-byte permutation
// RAM (read s[i], read s[j], write s[i] with read s[c], write s[j]), so that
// RAM sets the rate. An absorb item is accept plus four round steps, an init
// item accept plus an init step (the permutation and digest store are reset
// through per-entry valid bits, no clearing pass), and a finalize item accept
// plus FINAL_ROUNDS rounds and a read and a fold step per digest byte (a fold
// waits while the result register is full); a finalize round also fetches
// s[k]. The result register lets the next item be accepted while the last
// digest byte still waits to be taken. After reset the block is ready at once.
module permutation_byte_hash #(
	parameter int DIGEST_BYTES = 32,
	parameter int FINAL_ROUNDS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] digest_byte,
	output logic [4:0] byte_index,
	output logic       last
);

	import pbh_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// control sequencer
	pbh_useq u_useq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (action),
		.stat       (stat),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	// datapath and storage
	pbh_dp #(
		.DIGEST_BYTES (DIGEST_BYTES),
		.FINAL_ROUNDS (FINAL_ROUNDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.data_byte    (data_byte),
		.result_ready (result_ready),
		.stat         (stat),
		.result_valid (result_valid),
		.digest_byte  (digest_byte),
		.byte_index   (byte_index),
		.last         (last)
	);

endmodule
